// File: rtl/core/tga_pkg.sv
// ---------------------------------------------------------------------------
// tga_pkg
// Shared types, constants and helpers for the gather-along-axis block.
// ---------------------------------------------------------------------------
package tga_pkg;

  // field and counter widths
  localparam int SIZE_W     = 13;
  localparam int CNT_W      = 12;
  localparam int IDX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int SIZE_MAX   = 4096;
  localparam int STRIDE_W   = 2 * SIZE_W;
  localparam int PROD_W     = IDX_W + SIZE_W;
  // base (< 2^36) plus index product and inner offset (< 2^29)
  localparam int ADDR_SUM_W = 37;

  // parameter defaults
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int DATA_WIDTH_DEF  = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BEFORE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_AXIS_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_AXIS_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AFTER_COUNT     = 3'd3;

  // effective tensor sizes
  typedef struct packed {
    logic [SIZE_W-1:0] bef;
    logic [SIZE_W-1:0] slen;
    logic [SIZE_W-1:0] ilen;
    logic [SIZE_W-1:0] aft;
  } tga_size_t;

  // controls into the address generator
  typedef struct packed {
    logic capture;
    logic step;
    logic restart;
  } tga_gen_ctl_t;

  // address generator results
  typedef struct packed {
    logic [ADDR_SUM_W-1:0] addr;
    logic                  bad_idx;
    logic                  last;
  } tga_gen_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_DATA
  } tga_state_t;

  // clamp a size register to 1..SIZE_MAX
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(SIZE_MAX)) r = SIZE_W'(SIZE_MAX);
    return r;
  endfunction

endpackage

// File: rtl/core/tga_ram.sv
// ---------------------------------------------------------------------------
// tga_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module tga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tga_addr_gen.sv
// ---------------------------------------------------------------------------
// tga_addr_gen
// Position counters and source address for each gather word, with the
// outer base kept as a running sum of the per-outer stride.
// ---------------------------------------------------------------------------
module tga_addr_gen (
  input  logic                        clk,
  input  logic                        rst,
  input  tga_pkg::tga_size_t          size,
  input  tga_pkg::tga_gen_ctl_t       ctl,
  input  logic [tga_pkg::IDX_W-1:0]   index_value,
  output tga_pkg::tga_gen_res_t       res
);
  import tga_pkg::*;

  logic [IDX_W-1:0]      idx_q;
  logic [CNT_W-1:0]      outer;
  logic [CNT_W-1:0]      axis;
  logic [CNT_W-1:0]      inner;
  logic [ADDR_SUM_W-1:0] base;
  logic [STRIDE_W-1:0]   stride;
  logic [PROD_W-1:0]     prod;
  logic [ADDR_SUM_W-1:0] part;
  logic                  bad_idx;
  logic                  last_q;
  logic                  inner_end;
  logic                  axis_end;
  logic                  outer_end;
  logic                  last_c;

  // end-of-dimension flags
  assign inner_end = ({1'b0, inner} + SIZE_W'(1)) >= size.aft;
  assign axis_end  = ({1'b0, axis}  + SIZE_W'(1)) >= size.ilen;
  assign outer_end = ({1'b0, outer} + SIZE_W'(1)) >= size.bef;
  assign last_c    = inner_end && axis_end && outer_end;

  // index word capture
  always_ff @(posedge clk) begin
    if (ctl.capture) idx_q <= index_value;
  end

  // stride of one outer step, refreshed every cycle
  always_ff @(posedge clk) begin
    stride <= size.aft * size.slen;
  end

  // address terms for the captured word
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod    <= idx_q * size.aft;
      part    <= base + ADDR_SUM_W'(inner);
      bad_idx <= {1'b0, idx_q} >= (IDX_W+1)'(size.slen);
      last_q  <= last_c;
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      outer <= '0;
      axis  <= '0;
      inner <= '0;
      base  <= '0;
    end else if (ctl.step) begin
      if (last_c) begin
        outer <= '0;
        axis  <= '0;
        inner <= '0;
        base  <= '0;
      end else if (!inner_end) begin
        inner <= inner + CNT_W'(1);
      end else begin
        inner <= '0;
        if (!axis_end) begin
          axis <= axis + CNT_W'(1);
        end else begin
          axis  <= '0;
          outer <= outer + CNT_W'(1);
          base  <= base + ADDR_SUM_W'(stride);
        end
      end
    end
  end

  assign res.addr    = ADDR_SUM_W'(prod) + part;
  assign res.bad_idx = bad_idx;
  assign res.last    = last_q;

endmodule

// File: rtl/core/tensor_gather_along_axis.sv
// ---------------------------------------------------------------------------
// tensor_gather_along_axis
// Gather along one axis of a row-major tensor held in an on-chip store.
// ---------------------------------------------------------------------------
// Input words (in_valid/in_ready) carry a mode bit: a load word appends
// source_value to the store (ignored once the store is full), a gather word
// supplies one index element in row-major order of the index tensor.
// Each gather word gives one output word (out_valid/out_ready) with the
// fetched element, an out_of_range flag (value zero) and last on the final
// element of the index tensor; load words give none.
// A load word is written to the store as it is accepted. The index is captured as a gather is
// accepted; out_valid rises after the stages index multiply and counter
// step, address add and store read, data. No new word is accepted until
// the gather has left its data stage and the sequencer is idle again.
// The output register lets the next word in while a result waits; if the
// receiver stalls, a following gather holds in its data stage.
// Size register writes (cfg_we) set the tensor sizes and restart the
// gather position; loaded data is kept. Reset clears the load pointer and
// position and sets every size to one; the store needs no clearing.
// ---------------------------------------------------------------------------
module tensor_gather_along_axis #(
  parameter int STORE_DEPTH = tga_pkg::STORE_DEPTH_DEF,
  parameter int DATA_WIDTH  = tga_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tga_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [DATA_WIDTH-1:0]         source_value,
  input  logic [tga_pkg::IDX_W-1:0]     index_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DATA_WIDTH-1:0]         gathered_value,
  output logic                          out_of_range,
  output logic                          last
);
  import tga_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int LPW = $clog2(STORE_DEPTH) + 1;

  logic [SIZE_W-1:0]     before_count;
  logic [SIZE_W-1:0]     source_axis_len;
  logic [SIZE_W-1:0]     index_axis_len;
  logic [SIZE_W-1:0]     after_count;
  logic                  cfg_hit;
  tga_size_t             size;
  tga_gen_ctl_t          gen_ctl;
  tga_gen_res_t          gen_res;
  tga_state_t            state;
  tga_state_t            state_next;
  logic [LPW-1:0]        load_pointer;
  logic                  in_take;
  logic                  load_take;
  logic                  gather_take;
  logic                  store_we;
  logic                  rd_en;
  logic                  bad_addr;
  logic                  bad;
  logic                  bad_q;
  logic                  last_q;
  logic                  out_load;
  logic [DATA_WIDTH-1:0] rdata;

  assign in_take     = in_valid && in_ready;
  assign load_take   = in_take && !mode;
  assign gather_take = in_take && mode;

  // configuration registers
  always_comb begin
    case (cfg_index)
      REG_BEFORE_COUNT, REG_SOURCE_AXIS_LEN,
      REG_INDEX_AXIS_LEN, REG_AFTER_COUNT: cfg_hit = cfg_we;
      default:                             cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      before_count    <= SIZE_W'(1);
      source_axis_len <= SIZE_W'(1);
      index_axis_len  <= SIZE_W'(1);
      after_count     <= SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BEFORE_COUNT:    before_count    <= cfg_data;
        REG_SOURCE_AXIS_LEN: source_axis_len <= cfg_data;
        REG_INDEX_AXIS_LEN:  index_axis_len  <= cfg_data;
        REG_AFTER_COUNT:     after_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign size.bef  = eff_size(before_count);
  assign size.slen = eff_size(source_axis_len);
  assign size.ilen = eff_size(index_axis_len);
  assign size.aft  = eff_size(after_count);

  // load pointer and store write
  assign store_we = load_take && (load_pointer < LPW'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) load_pointer <= '0;
    else if (store_we) load_pointer <= load_pointer + LPW'(1);
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (gather_take) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADDR;
      ST_ADDR: state_next = ST_DATA;
      ST_DATA: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sequencer outputs
  always_comb begin
    in_ready        = 1'b0;
    rd_en           = 1'b0;
    gen_ctl.capture = 1'b0;
    gen_ctl.step    = 1'b0;
    gen_ctl.restart = cfg_hit;
    out_load        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        gen_ctl.capture = gather_take;
      end
      ST_MUL:  gen_ctl.step = 1'b1;
      ST_ADDR: rd_en = 1'b1;
      ST_DATA: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  tga_addr_gen u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .size        (size),
    .ctl         (gen_ctl),
    .index_value (index_value),
    .res         (gen_res)
  );

  // range check against loaded extent and store size
  assign bad_addr = (gen_res.addr >= ADDR_SUM_W'(load_pointer))
                 || (gen_res.addr >= ADDR_SUM_W'(STORE_DEPTH));
  assign bad      = gen_res.bad_idx || bad_addr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      bad_q  <= bad;
      last_q <= gen_res.last;
    end
  end

  tga_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (load_pointer[AW-1:0]),
    .wdata (source_value),
    .re    (rd_en),
    .raddr (gen_res.addr[AW-1:0]),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      gathered_value <= bad_q ? '0 : rdata;
      out_of_range   <= bad_q;
      last           <= last_q;
    end
  end

`ifndef SYNTH
  a_gather_enters_mul: assert property (@(posedge clk) disable iff (rst)
    gather_take |=> state == ST_MUL)
    else $error("gather word did not enter multiply stage");

  a_read_then_data: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADDR |=> state == ST_DATA)
    else $error("store read not followed by data stage");

  a_pointer_bound: assert property (@(posedge clk) disable iff (rst)
    load_pointer <= LPW'(STORE_DEPTH))
    else $error("load pointer beyond store depth");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> gathered_value == '0)
    else $error("out-of-range word carries a non-zero value");
`endif

endmodule

// File: dv/tensor_gather_along_axis_tb.sv
// ---------------------------------------------------------------------------
// tensor_gather_along_axis_tb
// Self-checking bench for the gather-along-axis block. Load and gather words
// are queued by a stimulus process and sent by a bursty driver; a shadow of
// the store, the load pointer and the row-major position predicts every
// gathered word, and a monitor compares each output word field by field
// while the receiver stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module tensor_gather_along_axis_tb;
  import tga_pkg::*;

  localparam int STORE_DEPTH   = 256;
  localparam int DATA_W        = DATA_WIDTH_DEF;
  localparam int ITEM_TARGET   = 1550;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PASS_CAP      = 48;
  localparam int MAX_PRINTED   = 100;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_GATHER = 1'b1;

  // first register index that the block ignores
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 3'd4;

  typedef struct {
    logic              mode;
    logic [DATA_W-1:0] source;
    logic [IDX_W-1:0]  index;
  } tensor_word_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              out_of_range;
    logic              last;
  } gathered_word_t;

  typedef enum int {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_PERIODIC
  } rx_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 mode = MODE_LOAD;
  logic [DATA_W-1:0]    source_value = '0;
  logic [IDX_W-1:0]     index_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DATA_W-1:0]    gathered_value;
  logic                 out_of_range;
  logic                 last;

  // words waiting to be sent and gathered words still owed by the block
  tensor_word_t   words_to_send[$];
  gathered_word_t expected_gathers[$];

  // shadow of the block state
  logic [DATA_W-1:0] shadow_store [STORE_DEPTH];
  longint unsigned   fill_level;
  longint unsigned   pos_outer;
  longint unsigned   pos_axis;
  longint unsigned   pos_inner;
  logic [SIZE_W-1:0] size_reg [4];

  int unsigned    error_count = 0;
  int unsigned    results_seen = 0;
  int unsigned    cycle_count = 0;
  int unsigned    item_count = 0;
  int unsigned    loads_planned = 0;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;
  logic           offer;
  int unsigned    style_left = 0;
  int unsigned    hold_left = 0;
  rx_style_t      rx_style = RX_OPEN;
  logic           ready_next;
  logic           long_hold_req = 1'b0;
  logic           long_hold_done = 1'b0;
  gathered_word_t want;

  tensor_gather_along_axis #(
    .STORE_DEPTH (STORE_DEPTH),
    .DATA_WIDTH  (DATA_W)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .source_value   (source_value),
    .index_value    (index_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .gathered_value (gathered_value),
    .out_of_range   (out_of_range),
    .last           (last)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // size register as the block uses it
  function automatic longint unsigned clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIZE_W'(SIZE_MAX)) return SIZE_MAX;
    return v;
  endfunction

  // work out what one accepted word does to the store and position
  function automatic void predict_tensor_word(input tensor_word_t w);
    longint unsigned bef, slen, ilen, aft, idx, addr;
    gathered_word_t  g;
    bef  = clamp_size(size_reg[REG_BEFORE_COUNT]);
    slen = clamp_size(size_reg[REG_SOURCE_AXIS_LEN]);
    ilen = clamp_size(size_reg[REG_INDEX_AXIS_LEN]);
    aft  = clamp_size(size_reg[REG_AFTER_COUNT]);
    if (w.mode == MODE_LOAD) begin
      // a full store drops the word
      if (fill_level < STORE_DEPTH) begin
        shadow_store[fill_level] = w.source;
        fill_level++;
      end
    end else begin
      idx  = w.index;
      addr = pos_inner + idx * aft + pos_outer * aft * slen;
      g.out_of_range = (idx >= slen) || (addr >= fill_level) || (addr >= STORE_DEPTH);
      g.value = '0;
      if (!g.out_of_range) g.value = shadow_store[addr];
      g.last = (pos_outer + 1 >= bef) && (pos_axis + 1 >= ilen) && (pos_inner + 1 >= aft);
      expected_gathers.push_back(g);
      // step through the index tensor in row-major order
      if (g.last) begin
        pos_outer = 0;
        pos_axis  = 0;
        pos_inner = 0;
      end else if (pos_inner + 1 < aft) begin
        pos_inner++;
      end else begin
        pos_inner = 0;
        if (pos_axis + 1 < ilen) begin
          pos_axis++;
        end else begin
          pos_axis = 0;
          pos_outer++;
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp_val);
    if (error_count < MAX_PRINTED)
      $display("[%0d] result %0d: %s got %0h expected %0h", cycle_count, results_seen,
               what, got, exp_val);
    error_count++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // driver: bursts of words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        predict_tensor_word(words_to_send[0]);
        void'(words_to_send.pop_front());
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (words_to_send.size() != 0) begin
          offer = 1'b1;
          mode         <= words_to_send[0].mode;
          source_value <= words_to_send[0].source;
          index_value  <= words_to_send[0].index;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // receiver: random stall styles that change from time to time, plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style   = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      if (long_hold_req && !long_hold_done) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN:   ready_next = 1'b1;
          RX_HALF:   ready_next = 1'($urandom_range(0, 1));
          RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
          default:   ready_next = (cycle_count % 3 == 0);
        endcase
      end
      out_ready <= ready_next;
    end
  end

  // monitor: compare each output word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_gathers.size() == 0) begin
        report_mismatch("word with nothing expected, value", gathered_value, 0);
      end else begin
        want = expected_gathers.pop_front();
        if (gathered_value !== want.value)
          report_mismatch("gathered_value", gathered_value, want.value);
        if (out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", out_of_range, want.out_of_range);
        if (last !== want.last)
          report_mismatch("last", last, want.last);
      end
    end
  end

  // register write, taken into the shadow at the same edge
  task automatic write_size(input logic [CFG_IDX_W-1:0] which, input logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which <= REG_AFTER_COUNT) begin
      size_reg[which] = val;
      pos_outer = 0;
      pos_axis  = 0;
      pos_inner = 0;
    end
  endtask

  task automatic write_all_sizes(input logic [SIZE_W-1:0] bef, input logic [SIZE_W-1:0] slen,
                                 input logic [SIZE_W-1:0] ilen, input logic [SIZE_W-1:0] aft);
    write_size(REG_BEFORE_COUNT, bef);
    write_size(REG_SOURCE_AXIS_LEN, slen);
    write_size(REG_INDEX_AXIS_LEN, ilen);
    write_size(REG_AFTER_COUNT, aft);
  endtask

  task automatic push_load(input logic [DATA_W-1:0] v);
    tensor_word_t w;
    w.mode   = MODE_LOAD;
    w.source = v;
    w.index  = IDX_W'($urandom);
    words_to_send.push_back(w);
    if (loads_planned < STORE_DEPTH) item_count++;
    loads_planned++;
  endtask

  task automatic push_gather(input logic [IDX_W-1:0] idx);
    tensor_word_t w;
    w.mode   = MODE_GATHER;
    w.source = DATA_W'($urandom);
    w.index  = idx;
    words_to_send.push_back(w);
    item_count++;
  endtask

  // let every queued word go and every result come back
  task automatic wait_idle();
    while (words_to_send.size() != 0 || expected_gathers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly small sizes, now and then an extreme or an out-of-range setting
  function automatic logic [SIZE_W-1:0] pick_size(input int unsigned small_max);
    case ($urandom_range(0, 39))
      0:       return '0;
      1:       return SIZE_W'(SIZE_MAX);
      2:       return '1;
      3:       return SIZE_W'($urandom_range(SIZE_MAX + 1, 8191));
      4:       return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(1, small_max));
    endcase
  endfunction

  // mostly legal positions, some just past the axis, some anywhere
  function automatic logic [IDX_W-1:0] pick_index(input longint unsigned slen);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 15) return IDX_W'($urandom_range(0, 32'(slen - 1)));
    if (roll < 17) return IDX_W'(slen);
    if (roll == 17) return '1;
    return IDX_W'($urandom);
  endfunction

  // stimulus
  initial begin
    longint unsigned pass_len;
    longint unsigned slen_eff;
    int unsigned     passes;
    int unsigned     load_odds;
    logic            hold_phase_done;

    fill_level = 0;
    pos_outer  = 0;
    pos_axis   = 0;
    pos_inner  = 0;
    for (int r = 0; r < 4; r++) size_reg[r] = SIZE_W'(1);
    hold_phase_done = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: gather before any load, then a few loads at the data extremes
    push_gather('0);
    push_load('1);
    push_load('0);
    push_load(32'hA5A5_A5A5);
    push_load(32'h5A5A_5A5A);
    push_gather('0);
    push_gather(IDX_W'(1));
    push_gather('1);
    wait_idle();

    // one full pass over a small index tensor, then the start of the next
    write_all_sizes(SIZE_W'(2), SIZE_W'(2), SIZE_W'(3), SIZE_W'(1));
    push_gather(IDX_W'(0));
    push_gather(IDX_W'(1));
    push_gather(IDX_W'(1));
    push_gather(IDX_W'(0));
    push_gather(IDX_W'(0));
    push_gather(IDX_W'(1));
    push_gather(IDX_W'(16'h8000));
    wait_idle();

    // a write to an unused register index must not move the position
    write_size(REG_SPARE_LOW + CFG_IDX_W'(3), '1);
    push_gather(IDX_W'(1));
    wait_idle();

    // zero sizes behave as one
    write_all_sizes('0, '0, '0, '0);
    push_gather('0);
    wait_idle();

    // oversized registers clamp to the largest size
    write_all_sizes('1, SIZE_W'(SIZE_MAX + 1), SIZE_W'(SIZE_MAX), '1);
    push_gather(IDX_W'(SIZE_MAX - 1));
    push_gather(IDX_W'(SIZE_MAX));
    push_gather('0);
    wait_idle();

    // outer stride past the store
    write_all_sizes(SIZE_W'(4), SIZE_W'(SIZE_MAX), SIZE_W'(1), SIZE_W'(1));
    push_gather(IDX_W'(3));
    push_gather(IDX_W'(100));
    push_gather(IDX_W'(SIZE_MAX - 1));
    push_gather('0);
    wait_idle();

    // stream of loads to give the gathers something to hit
    for (int k = 0; k < 100; k++) push_load(DATA_W'($urandom));
    wait_idle();

    // random phases: a setting, then whole or broken passes
    while (item_count < ITEM_TARGET) begin
      if (!hold_phase_done && item_count >= ITEM_TARGET / 2) begin
        // receiver holds off while the sender keeps offering
        hold_phase_done = 1'b1;
        write_all_sizes(SIZE_W'(2), SIZE_W'(4), SIZE_W'(4), SIZE_W'(2));
        long_hold_req <= 1'b1;
        for (int k = 0; k < PASS_CAP; k++) push_gather(pick_index(4));
        wait_idle();
      end

      write_size(REG_BEFORE_COUNT, pick_size(4));
      if ($urandom_range(0, 3) != 0) write_size(REG_SOURCE_AXIS_LEN, pick_size(8));
      if ($urandom_range(0, 3) != 0) write_size(REG_INDEX_AXIS_LEN, pick_size(8));
      if ($urandom_range(0, 3) != 0) write_size(REG_AFTER_COUNT, pick_size(4));
      if ($urandom_range(0, 7) == 0)
        write_size(REG_SPARE_LOW + CFG_IDX_W'($urandom_range(0, 3)), SIZE_W'($urandom));

      slen_eff = clamp_size(size_reg[REG_SOURCE_AXIS_LEN]);
      passes   = $urandom_range(1, 3);
      for (int p = 0; p < passes; p++) begin
        pass_len = clamp_size(size_reg[REG_BEFORE_COUNT])
                 * clamp_size(size_reg[REG_INDEX_AXIS_LEN])
                 * clamp_size(size_reg[REG_AFTER_COUNT]);
        if (pass_len > PASS_CAP) pass_len = $urandom_range(1, PASS_CAP);
        else if ($urandom_range(0, 9) == 0) pass_len = $urandom_range(1, 32'(pass_len));
        for (longint unsigned k = 0; k < pass_len; k++) begin
          // keep loading until the store overflows, then only as noise
          load_odds = (loads_planned < STORE_DEPTH + 16) ? 6 : 40;
          if ($urandom_range(1, load_odds) == 1) push_load(DATA_W'($urandom));
          push_gather(pick_index(slen_eff));
        end
      end
      wait_idle();
    end

    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
